// File: rtl/prr_pkg.sv
// Shared types and constants for the pressure row relaxation unit.
// No dependencies.
package prr_pkg;

  localparam int DATA_W = 32;
  localparam int VERT_W = 34;
  localparam int SUM_W  = 36;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam logic [1:0] PHASE_START  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;
  localparam logic [1:0] PHASE_STEADY = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] pressure_here;
    logic signed [DATA_W-1:0] pressure_above;
    logic signed [DATA_W-1:0] pressure_below;
    logic signed [DATA_W-1:0] vel_x_here;
    logic signed [DATA_W-1:0] vel_y_above;
    logic signed [DATA_W-1:0] vel_y_below;
    logic                     row_end;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pressure_new;
    logic                     row_done;
  } out_item_t;

  typedef struct packed {
    logic [1:0] n;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

endpackage

// File: rtl/prr_relax.sv
// Relaxation datapath: five-term sum, saturation to 32 bits, floor divide by four.
// Depends on prr_pkg.
module prr_relax (
  input  logic signed [prr_pkg::DATA_W-1:0] left,
  input  logic signed [prr_pkg::DATA_W-1:0] right,
  input  logic signed [prr_pkg::DATA_W-1:0] vxl,
  input  logic signed [prr_pkg::DATA_W-1:0] vxr,
  input  logic signed [prr_pkg::VERT_W-1:0] vert,
  output logic signed [prr_pkg::DATA_W-1:0] result
);

  localparam logic signed [prr_pkg::SUM_W-1:0] SAT_MAX =
    prr_pkg::SUM_W'(64'sh7FFF_FFFF);
  localparam logic signed [prr_pkg::SUM_W-1:0] SAT_MIN =
    -prr_pkg::SUM_W'(64'sh8000_0000);

  logic signed [prr_pkg::SUM_W-1:0]  sum;
  logic signed [prr_pkg::DATA_W-1:0] sat;

  always_comb begin
    sum = prr_pkg::SUM_W'(left) + prr_pkg::SUM_W'(right) + prr_pkg::SUM_W'(vert)
        + prr_pkg::SUM_W'(vxl) - prr_pkg::SUM_W'(vxr);
    if (sum > SAT_MAX) begin
      sat = prr_pkg::DATA_W'(SAT_MAX);
    end else if (sum < SAT_MIN) begin
      sat = prr_pkg::DATA_W'(SAT_MIN);
    end else begin
      sat = sum[prr_pkg::DATA_W-1:0];
    end
    result = sat >>> 2;
  end

endmodule

// File: rtl/prr_out_fifo.sv
// Result queue: takes up to two items per cycle, hands out one while out_stall is low.
// Depends on prr_pkg.
module prr_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  prr_pkg::push_t     push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output prr_pkg::out_item_t out_data
);

  prr_pkg::out_item_t mem [prr_pkg::FIFO_DEPTH];

  logic [prr_pkg::FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [prr_pkg::FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [prr_pkg::FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign room      = (cnt_r <= prr_pkg::FIFO_CNT_W'(prr_pkg::FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + prr_pkg::FIFO_PTR_W'(push.n);
    rd_ptr_nxt = rd_ptr_r + prr_pkg::FIFO_PTR_W'(pop);
    cnt_nxt    = cnt_r + prr_pkg::FIFO_CNT_W'(push.n) - prr_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr_r] <= push.item0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_r + prr_pkg::FIFO_PTR_W'(1)] <= push.item1;
    end
  end

endmodule

// File: rtl/pressure_row_relaxation_unit.sv
// Top level of the pressure row relaxation unit: input register, row state and
// relaxation datapath, result queue. Depends on prr_pkg, prr_relax, prr_out_fifo.
//
// Relaxes one row of a Q16.16 pressure grid streamed one element per item in
// row order, one item per clock sustained while in_stall is low. Each item is
// captured in an input register; once the queue has room, its results (none,
// one or two) go into a four-entry result queue, from which one result leaves
// per cycle while out_stall is low. The result for element i appears once
// element i+1 has been taken. The first two items of a row of three or more
// give nothing and the third gives two, so rows stream without bubbles.
// in_stall rises only when the queue has fewer than two free entries while an
// item waits in the input register, i.e. under output back-pressure.
module pressure_row_relaxation_unit #(
  parameter int LANES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  prr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output prr_pkg::out_item_t out_data
);

  localparam int LANE_W = $clog2(LANES);
  localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(LANES - 1);

  // input register
  logic                                s1_valid_r, s1_valid_nxt;
  logic signed [prr_pkg::DATA_W-1:0]   s1_p_r;
  logic signed [prr_pkg::DATA_W-1:0]   s1_vx_r;
  logic signed [prr_pkg::VERT_W-1:0]   s1_vert_r;
  logic                                s1_last_r;
  logic signed [prr_pkg::VERT_W-1:0]   in_vert;

  // row state
  logic signed [prr_pkg::DATA_W-1:0]   win0_r, win0_nxt, win1_r, win1_nxt;
  logic signed [prr_pkg::DATA_W-1:0]   vx0_r, vx0_nxt, vx1_r, vx1_nxt;
  logic signed [prr_pkg::VERT_W-1:0]   vhold_r, vhold_nxt;
  logic signed [prr_pkg::DATA_W-1:0]   fresh_r, fresh_nxt;
  logic [LANE_W-1:0]                   lane_r, lane_nxt;
  logic [1:0]                          phase_r, phase_nxt;

  logic                                in_accept, adv, room;
  logic signed [prr_pkg::DATA_W-1:0]   rl_left, rl_right, rl_vxl, rl_vxr, rl_result;
  logic signed [prr_pkg::VERT_W-1:0]   rl_vert;
  prr_pkg::push_t                      push;

  assign adv       = s1_valid_r && room;
  assign in_stall  = s1_valid_r && !room;
  assign in_accept = in_valid && !in_stall;

  assign in_vert = prr_pkg::VERT_W'(in_data.pressure_above)
                 + prr_pkg::VERT_W'(in_data.pressure_below)
                 + prr_pkg::VERT_W'(in_data.vel_y_above)
                 - prr_pkg::VERT_W'(in_data.vel_y_below);

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_p_r    <= in_data.pressure_here;
      s1_vx_r   <= in_data.vel_x_here;
      s1_vert_r <= in_vert;
      s1_last_r <= in_data.row_end;
    end
  end

  // relaxation operand select
  always_comb begin
    case (phase_r)
      prr_pkg::PHASE_START: begin
        rl_left  = '0;
        rl_right = '0;
        rl_vxl   = '0;
        rl_vxr   = '0;
        rl_vert  = s1_vert_r;
      end
      prr_pkg::PHASE_SECOND: begin
        rl_left  = win1_r;
        rl_right = '0;
        rl_vxl   = vx1_r;
        rl_vxr   = '0;
        rl_vert  = s1_vert_r;
      end
      default: begin
        rl_left  = (lane_r == '0) ? fresh_r : win0_r;
        rl_right = s1_p_r;
        rl_vxl   = vx0_r;
        rl_vxr   = s1_vx_r;
        rl_vert  = vhold_r;
      end
    endcase
  end

  prr_relax u_relax (
    .left   (rl_left),
    .right  (rl_right),
    .vxl    (rl_vxl),
    .vxr    (rl_vxr),
    .vert   (rl_vert),
    .result (rl_result)
  );

  // row sequencing
  always_comb begin
    win0_nxt  = win0_r;
    win1_nxt  = win1_r;
    vx0_nxt   = vx0_r;
    vx1_nxt   = vx1_r;
    vhold_nxt = vhold_r;
    fresh_nxt = fresh_r;
    lane_nxt  = lane_r;
    phase_nxt = phase_r;

    push.n                  = 2'd0;
    push.item0.pressure_new = rl_result;
    push.item0.row_done     = 1'b0;
    push.item1.pressure_new = rl_result;
    push.item1.row_done     = s1_last_r;

    if (adv) begin
      case (phase_r)
        prr_pkg::PHASE_START: begin
          if (s1_last_r) begin
            push.n              = 2'd1;
            push.item0.row_done = 1'b1;
          end
        end
        prr_pkg::PHASE_SECOND: begin
          if (s1_last_r) begin
            push.n = 2'd2;
          end
        end
        default: begin
          push.n = (phase_r == prr_pkg::PHASE_THIRD || s1_last_r) ? 2'd2 : 2'd1;
        end
      endcase

      if (s1_last_r) begin
        win0_nxt  = '0;
        win1_nxt  = '0;
        vx0_nxt   = '0;
        vx1_nxt   = '0;
        vhold_nxt = '0;
        fresh_nxt = '0;
        lane_nxt  = '0;
        phase_nxt = prr_pkg::PHASE_START;
      end else begin
        win0_nxt  = win1_r;
        win1_nxt  = s1_p_r;
        vx0_nxt   = vx1_r;
        vx1_nxt   = s1_vx_r;
        vhold_nxt = s1_vert_r;
        case (phase_r)
          prr_pkg::PHASE_START: begin
            lane_nxt  = '0;
            phase_nxt = prr_pkg::PHASE_SECOND;
          end
          prr_pkg::PHASE_SECOND: begin
            lane_nxt  = LANE_W'(1);
            phase_nxt = prr_pkg::PHASE_THIRD;
          end
          default: begin
            fresh_nxt = rl_result;
            lane_nxt  = (lane_r == LANE_LAST) ? '0 : lane_r + LANE_W'(1);
            phase_nxt = prr_pkg::PHASE_STEADY;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r  <= '0;
      win1_r  <= '0;
      vx0_r   <= '0;
      vx1_r   <= '0;
      vhold_r <= '0;
      fresh_r <= '0;
      lane_r  <= '0;
      phase_r <= prr_pkg::PHASE_START;
    end else begin
      win0_r  <= win0_nxt;
      win1_r  <= win1_nxt;
      vx0_r   <= vx0_nxt;
      vx1_r   <= vx1_nxt;
      vhold_r <= vhold_nxt;
      fresh_r <= fresh_nxt;
      lane_r  <= lane_nxt;
      phase_r <= phase_nxt;
    end
  end

  prr_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/prr_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the pressure row relaxation unit: follows the row state,
// predicts each relaxed pressure and compares it with the result channel.
// Depends on prr_pkg.
module prr_result_checker #(
  parameter int LANES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  prr_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  prr_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending_count,
  output int                 results_checked
);

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  logic signed [prr_pkg::DATA_W-1:0] old_pressure [2];
  logic signed [prr_pkg::DATA_W-1:0] old_vel_x [2];
  logic signed [prr_pkg::VERT_W-1:0] vert_hold;
  logic signed [prr_pkg::DATA_W-1:0] fresh_left;
  int unsigned                       lane_pos;
  logic [1:0]                        phase;
  prr_pkg::out_item_t                expected_pressures [$];
  int                                fails = 0;
  int                                checked = 0;

  function automatic logic signed [prr_pkg::DATA_W-1:0] relaxed_pressure(
    input longint left, input longint right, input longint vx_left,
    input longint vx_right, input longint vert
  );
    longint s;
    s = left + right + vert + vx_left - vx_right;
    if (s > SAT_HI) s = SAT_HI;
    if (s < SAT_LO) s = SAT_LO;
    return prr_pkg::DATA_W'(s >>> 2);
  endfunction

  function automatic void queue_pressure(input logic signed [prr_pkg::DATA_W-1:0] r,
                                         input logic done);
    prr_pkg::out_item_t e;
    e.pressure_new = r;
    e.row_done = done;
    expected_pressures.push_back(e);
  endfunction

  function automatic void clear_row();
    old_pressure[0] = '0;
    old_pressure[1] = '0;
    old_vel_x[0] = '0;
    old_vel_x[1] = '0;
    vert_hold = '0;
    fresh_left = '0;
    lane_pos = 0;
    phase = prr_pkg::PHASE_START;
  endfunction

  function automatic void shift_window(input logic signed [prr_pkg::DATA_W-1:0] p,
                                       input logic signed [prr_pkg::DATA_W-1:0] vx);
    old_pressure[0] = old_pressure[1];
    old_pressure[1] = p;
    old_vel_x[0] = old_vel_x[1];
    old_vel_x[1] = vx;
  endfunction

  function automatic void take_element(input prr_pkg::in_item_t it);
    logic signed [prr_pkg::VERT_W-1:0] vert;
    logic signed [prr_pkg::DATA_W-1:0] p;
    logic signed [prr_pkg::DATA_W-1:0] vx;
    logic signed [prr_pkg::DATA_W-1:0] left;
    logic signed [prr_pkg::DATA_W-1:0] r;
    p = $signed(it.pressure_here);
    vx = $signed(it.vel_x_here);
    vert = $signed(it.pressure_above) + $signed(it.pressure_below)
         + $signed(it.vel_y_above) - $signed(it.vel_y_below);
    if (phase == prr_pkg::PHASE_START) begin
      if (it.row_end) begin
        queue_pressure(relaxed_pressure(0, 0, 0, 0, vert), 1'b1);
        clear_row();
      end else begin
        old_pressure[1] = p;
        old_vel_x[1] = vx;
        vert_hold = vert;
        lane_pos = 0;
        phase = prr_pkg::PHASE_SECOND;
      end
    end else if (phase == prr_pkg::PHASE_SECOND) begin
      if (it.row_end) begin
        r = relaxed_pressure(old_pressure[1], 0, old_vel_x[1], 0, vert);
        queue_pressure(r, 1'b0);
        queue_pressure(r, 1'b1);
        clear_row();
      end else begin
        shift_window(p, vx);
        vert_hold = vert;
        lane_pos = 1 % LANES;
        phase = prr_pkg::PHASE_THIRD;
      end
    end else begin
      left = (lane_pos == 0) ? fresh_left : old_pressure[0];
      r = relaxed_pressure(left, p, old_vel_x[0], vx, vert_hold);
      queue_pressure(r, 1'b0);
      if (phase == prr_pkg::PHASE_THIRD || it.row_end) queue_pressure(r, it.row_end);
      if (it.row_end) begin
        clear_row();
      end else begin
        fresh_left = r;
        shift_window(p, vx);
        vert_hold = vert;
        lane_pos = (lane_pos + 1) % LANES;
        phase = prr_pkg::PHASE_STEADY;
      end
    end
  endfunction

  always @(posedge clk) begin
    prr_pkg::out_item_t e;
    if (!rst_n) begin
      clear_row();
      expected_pressures.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pressures.size() == 0) begin
          $error("unexpected result: pressure_new %0d row_done %0b",
                 $signed(out_data.pressure_new), out_data.row_done);
          fails++;
        end else begin
          e = expected_pressures.pop_front();
          checked++;
          if (out_data.pressure_new !== e.pressure_new) begin
            $error("pressure_new: expected %0d, got %0d",
                   $signed(e.pressure_new), $signed(out_data.pressure_new));
            fails++;
          end
          if (out_data.row_done !== e.row_done) begin
            $error("row_done: expected %0b, got %0b", e.row_done, out_data.row_done);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) take_element(in_data);
    end
    fail_count <= fails;
    pending_count <= expected_pressures.size();
    results_checked <= checked;
  end

endmodule

// File: tb/pressure_row_relaxation_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for the pressure row relaxation unit: streams directed and
// random rows with random idling on both sides and gives the verdict.
// Depends on prr_pkg, the unit's RTL and prr_result_checker.
module pressure_row_relaxation_unit_test;

  localparam int LANES          = 4;
  localparam int ITEM_TARGET    = 1150;
  localparam int SQUEEZE_AT     = 300;
  localparam int CALM_AT        = 1000;
  localparam int HOLD_CYCLES    = 120;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [31:0] MAXV  = 32'h7fff_ffff;
  localparam logic [31:0] MINV  = 32'h8000_0000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  prr_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  prr_pkg::out_item_t out_data;

  int fail_count;
  int pending_count;
  int results_checked;
  int items_sent = 0;
  int rows_sent = 0;
  int quiet_cycles = 0;
  int tx_rate = 1;
  int rx_rate = 1;
  bit calm = 1'b0;
  bit squeeze = 1'b0;
  bit held = 1'b0;

  always #5 clk = ~clk;

  pressure_row_relaxation_unit #(.LANES(LANES)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  prr_result_checker #(.LANES(LANES)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .results_checked(results_checked)
  );

  function automatic prr_pkg::in_item_t make_element(
    input logic [31:0] p, input logic [31:0] pa, input logic [31:0] pb,
    input logic [31:0] vx, input logic [31:0] va, input logic [31:0] vb,
    input logic is_last
  );
    prr_pkg::in_item_t it;
    it.pressure_here = p;
    it.pressure_above = pa;
    it.pressure_below = pb;
    it.vel_x_here = vx;
    it.vel_y_above = va;
    it.vel_y_below = vb;
    it.row_end = is_last;
    return it;
  endfunction

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 7))
      0: return MAXV;
      1: return MINV;
      2: return 32'($urandom_range(0, 2048)) - 32'd1024;
      3: return 32'($signed($urandom) >>> 8);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_element(input prr_pkg::in_item_t it);
    int gap;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (it.row_end) rows_sent++;
    if (!calm && tx_rate != 0 && $urandom_range(0, 7) < tx_rate) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_row(input int len);
    for (int i = 0; i < len; i++) begin
      send_element(make_element(rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                                rand_q16(), rand_q16(), i == len - 1));
    end
  endtask

  always begin
    repeat (64) @(posedge clk);
    tx_rate = $urandom_range(0, 3);
    rx_rate = $urandom_range(0, 3);
  end

  initial begin
    int burst;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (squeeze && !held) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        held = 1'b1;
      end else if (!calm && rx_rate != 0 && $urandom_range(0, 7) < rx_rate) begin
        burst = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int len;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // single-element rows: sum clipped high, clipped low
    send_element(make_element(MAXV, MAXV, MAXV, MAXV, MAXV, MINV, 1'b1));
    send_element(make_element(MINV, MINV, MINV, MINV, MINV, MAXV, 1'b1));
    // two-element row
    send_element(make_element(32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 1'b0));
    send_element(make_element(MINV, MAXV, MINV, MAXV, MINV, MAXV, 1'b1));
    // three-element row
    for (int i = 0; i < 3; i++) begin
      send_element(make_element(32'(i * 98304 - 70000), 32'h0001_8000, 32'(-i * 5),
                                32'(i * 4097), 32'hffff_0000, 32'(i + 7), i == 2));
    end
    // crosses two lane boundaries, negative sums for floor rounding
    for (int i = 0; i < 9; i++) begin
      send_element(make_element(32'(i * 65536 - 200000), 32'(-i * 1234567),
                                32'(i * 3), 32'(i * i * 4099 - 50000),
                                i[0] ? MAXV : MINV, 32'(-i - 1), i == 8));
    end
    // extremes inside a row
    send_element(make_element(MAXV, MAXV, MAXV, MINV, MAXV, MINV, 1'b0));
    send_element(make_element(MINV, MINV, MINV, MAXV, MINV, MAXV, 1'b0));
    send_element(make_element(MAXV, 32'd0, 32'd0, MINV, 32'd0, 32'd0, 1'b0));
    send_element(make_element(32'd0, MINV, MAXV, MAXV, MAXV, MINV, 1'b1));
    send_element(make_element('0, '0, '0, '0, '0, '0, 1'b1));

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= SQUEEZE_AT) squeeze = 1'b1;
      if (items_sent >= CALM_AT) calm = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: len = $urandom_range(1, 4);
        4, 5, 6, 7: len = $urandom_range(5, 16);
        default:    len = $urandom_range(17, 40);
      endcase
      send_random_row(len);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d rows, %0d elements; %0d relaxed pressures checked.",
             rows_sent, items_sent, results_checked);
    $display("Idling on both sides, one %0d-cycle output hold-off, LANES=%0d.",
             HOLD_CYCLES, LANES);
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
